// ===== hw/rtl/bht_pkg.sv =====
// ----------------------------------------------------------------------------
// bht_pkg
// Shared types and constants for the button hold tracker.
// ----------------------------------------------------------------------------
package bht_pkg;

    localparam int unsigned BUTTON_COUNT_DEF = 8;
    localparam int unsigned CNT_W            = 8;
    localparam int unsigned QUERY_W          = 3;
    localparam int unsigned S_TDATA_W        = 16;
    localparam int unsigned M_TDATA_W        = 40;
    localparam int unsigned PADDR_W          = 3;
    localparam int unsigned PDATA_W          = 32;

    localparam logic [CNT_W-1:0] RELEASE_MARK = 8'hFF;
    localparam logic [CNT_W-1:0] HOLD_MAX     = 8'hFE;

    localparam logic REG_HELD_TIME     = 1'b0;
    localparam logic REG_REPEAT_PERIOD = 1'b1;

    typedef struct packed {
        logic start;
        logic update;
        logic finish;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/bht_regs.sv =====
// ----------------------------------------------------------------------------
// bht_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module bht_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bht_pkg::PADDR_W-1:0]   paddr,
    input  logic [bht_pkg::PDATA_W-1:0]   pwdata,
    output logic [bht_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [bht_pkg::CNT_W-1:0]     o_held_time,
    output logic [bht_pkg::CNT_W-1:0]     o_repeat_period
);
    import bht_pkg::*;

    logic [CNT_W-1:0] r_held_time;
    logic [CNT_W-1:0] r_repeat_period;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_time     <= 8'd1;
            r_repeat_period <= 8'd1;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_HELD_TIME:     r_held_time     <= pwdata[CNT_W-1:0];
                REG_REPEAT_PERIOD: r_repeat_period <= pwdata[CNT_W-1:0];
                default:           r_held_time     <= r_held_time;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_HELD_TIME:     prdata[CNT_W-1:0] = r_held_time;
            REG_REPEAT_PERIOD: prdata[CNT_W-1:0] = r_repeat_period;
            default:           prdata = '0;
        endcase
    end

    assign o_held_time     = r_held_time;
    assign o_repeat_period = r_repeat_period;

endmodule

// ===== hw/rtl/bht_ctrl.sv =====
// ----------------------------------------------------------------------------
// bht_ctrl
// Sequencer that walks the buttons of one frame through the datapath.
// ----------------------------------------------------------------------------
module bht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bht_pkg::t_dp_sts  i_sts,
    output bht_pkg::t_dp_cmd  o_cmd
);
    import bht_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_UPDATE  = 4'b0010,
        S_FINISH  = 4'b0100,
        S_PUBLISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = i_sts.last ? S_PUBLISH : S_UPDATE;
            end
            S_PUBLISH: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/bht_datapath.sv =====
// ----------------------------------------------------------------------------
// bht_datapath
// Hold counters, shared remainder unit, mask build-up and output register.
// ----------------------------------------------------------------------------
module bht_datapath #(
    parameter int unsigned BUTTON_COUNT = bht_pkg::BUTTON_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bht_pkg::t_dp_cmd              i_cmd,
    output bht_pkg::t_dp_sts              o_sts,
    input  logic [bht_pkg::CNT_W-1:0]     i_raw_buttons,
    input  logic [bht_pkg::QUERY_W-1:0]   i_query_button,
    input  logic [bht_pkg::CNT_W-1:0]     i_held_time,
    input  logic [bht_pkg::CNT_W-1:0]     i_repeat_period,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [bht_pkg::M_TDATA_W-1:0] o_out_data
);
    import bht_pkg::*;

    localparam int unsigned IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    function automatic logic [CNT_W-1:0] f_rem_step4(
        input logic [CNT_W-1:0] rem_in,
        input logic [3:0]       bits,
        input logic [CNT_W-1:0] div
    );
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] r;
        r = rem_in;
        for (int k = 3; k >= 0; k--) begin
            t = {r, bits[k]};
            if (t >= {1'b0, div}) begin
                t = t - {1'b0, div};
            end
            r = t[CNT_W-1:0];
        end
        return r;
    endfunction

    logic [CNT_W-1:0]   r_cnt_mem [BUTTON_COUNT];
    logic [CNT_W-1:0]   r_raw;
    logic [QUERY_W-1:0] r_query;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_cur;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_pm;
    logic [CNT_W-1:0]   r_rm;
    logic [CNT_W-1:0]   r_hm;
    logic [CNT_W-1:0]   r_am;
    logic [CNT_W-1:0]   r_hf;
    logic               r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [CNT_W-1:0] cnt_old;
    logic [CNT_W-1:0] cnt_new;
    logic             down;
    logic [CNT_W-1:0] rem_fin;
    logic [CNT_W:0]   target;
    logic             hit_rep;

    assign cnt_old = r_cnt_mem[r_idx];
    assign down    = !r_raw[r_idx];

    always_comb begin
        if (down) begin
            if (cnt_old == RELEASE_MARK) begin
                cnt_new = '0;
            end else if (cnt_old >= HOLD_MAX) begin
                cnt_new = HOLD_MAX;
            end else begin
                cnt_new = cnt_old + 8'd1;
            end
        end else if (cnt_old == '0 || cnt_old == RELEASE_MARK) begin
            cnt_new = '0;
        end else begin
            cnt_new = RELEASE_MARK;
        end
    end

    assign rem_fin = f_rem_step4(r_rem, r_cur[3:0], i_repeat_period);
    assign target  = {1'b0, i_held_time} + 9'd1;
    assign hit_rep = (r_cur != '0) && (r_cur != RELEASE_MARK)
                   && ((i_repeat_period <= 8'd1) || (rem_fin == 8'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_cnt_mem[i] <= '0;
            end
        end else if (i_cmd.update) begin
            r_cnt_mem[r_idx] <= cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_raw   <= i_raw_buttons;
            r_query <= i_query_button;
            r_idx   <= '0;
            r_pm    <= '0;
            r_rm    <= '0;
            r_hm    <= '0;
            r_am    <= '0;
            r_hf    <= '0;
        end
        if (i_cmd.update) begin
            r_cur <= cnt_new;
            r_rem <= f_rem_step4('0, cnt_new[7:4], i_repeat_period);
        end
        if (i_cmd.finish) begin
            r_pm[r_idx] <= (r_cur == 8'd1);
            r_rm[r_idx] <= (r_cur == RELEASE_MARK);
            r_hm[r_idx] <= (r_cur != RELEASE_MARK) && ({1'b0, r_cur} == target);
            r_am[r_idx] <= hit_rep;
            if ((QUERY_W'(r_idx) == r_query) && (r_cur != RELEASE_MARK)) begin
                r_hf <= r_cur;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.publish) begin
            r_out_data <= {r_hf, r_am, r_hm, r_rm, r_pm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.last     = (r_idx == IDX_W'(BUTTON_COUNT - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

// ===== hw/rtl/button_hold_tracker_core.sv =====
// ----------------------------------------------------------------------------
// button_hold_tracker_core
// Per-frame button press, release, hold and auto-repeat tracker.
// ----------------------------------------------------------------------------
// One input transfer on s_axis is one frame tick: the raw active-low button
// byte and the index of the button whose hold count is reported. Each frame
// yields exactly one output transfer on m_axis with the pressed, released,
// held and repeat masks and the queried hold count.
// The frame is processed one button at a time, in two steps per button: the
// first updates the hold counter and divides its upper nibble, the second
// finishes the remainder against repeat_period and sets the mask bits. A new
// frame is taken only after the previous one has reached the output register.
// The result sits in an output register, so a new frame is accepted while it
// waits; if the receiver stalls, the next result waits inside until that
// register is free, and s_axis_tready stays low meanwhile.
// Reset clears all hold counters to idle and sets held_time and
// repeat_period to 1. Registers are written through the APB-style port.
// ----------------------------------------------------------------------------
module button_hold_tracker_core #(
    parameter int unsigned BUTTON_COUNT = bht_pkg::BUTTON_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] raw_buttons, [10:8] query_button, [15:11] zero
    input  logic [bht_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] pressed_mask, [15:8] released_mask, [23:16] held_mask,
    // [31:24] repeat_mask, [39:32] hold_frames
    output logic [bht_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bht_pkg::PADDR_W-1:0]   paddr,
    input  logic [bht_pkg::PDATA_W-1:0]   pwdata,
    output logic [bht_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import bht_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [CNT_W-1:0] held_time;
    logic [CNT_W-1:0] repeat_period;

    bht_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_held_time     (held_time),
        .o_repeat_period (repeat_period)
    );

    bht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bht_datapath #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_raw_buttons   (s_axis_tdata[CNT_W-1:0]),
        .i_query_button  (s_axis_tdata[CNT_W+QUERY_W-1:CNT_W]),
        .i_held_time     (held_time),
        .i_repeat_period (repeat_period),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_out_data      (m_axis_tdata)
    );

endmodule

// ===== hw/rtl/bht_checker.sv =====
// ----------------------------------------------------------------------------
// bht_checker
// Port-level checks for the button hold tracker, bound to the top level.
// ----------------------------------------------------------------------------
module bht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [bht_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bht_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import bht_pkg::*;

    logic s_xfer;
    logic [CNT_W-1:0] pm;
    logic [CNT_W-1:0] rm;
    logic [CNT_W-1:0] hm;
    logic [CNT_W-1:0] am;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign pm     = m_axis_tdata[7:0];
    assign rm     = m_axis_tdata[15:8];
    assign hm     = m_axis_tdata[23:16];
    assign am     = m_axis_tdata[31:24];

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> !s_axis_tready)
        else $error("input accepted again right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

    a_release_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (((pm | hm | am) & rm) == '0))
        else $error("released bit overlaps another mask");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_xfer))
        else $error("result appeared right after input transfer");

endmodule

bind button_hold_tracker_core bht_checker u_bht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button hold tracker.
// ----------------------------------------------------------------------------
// Frames go in on s_axis and a local model of the eight hold counters predicts
// the result of each accepted frame. Every result on m_axis is compared field
// by field with the oldest prediction. The run covers short directed frames,
// a hold long enough to saturate the counters, a long receiver stall, and
// random frames under several register settings. Registers are only written
// once every predicted result has come back.
// ----------------------------------------------------------------------------
module tb;
    import bht_pkg::*;

    localparam int unsigned BUTTONS      = BUTTON_COUNT_DEF;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          STALL_CYCLES = 400;

    localparam logic [PADDR_W-1:0] ADDR_HELD_TIME     = {REG_HELD_TIME, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_REPEAT_PERIOD = {REG_REPEAT_PERIOD, 2'b00};

    typedef struct packed {
        logic [CNT_W-1:0] hold_frames;
        logic [7:0]       repeat_mask;
        logic [7:0]       held_mask;
        logic [7:0]       released_mask;
        logic [7:0]       pressed_mask;
    } t_frame_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic [CNT_W-1:0] button_counts [BUTTONS] = '{default: '0};
    logic [7:0]       held_time     = 8'd1;
    logic [7:0]       repeat_period = 8'd1;

    t_frame_result expected_frames [$];
    int            mismatches  = 0;
    int            cycles      = 0;
    bit            src_gaps    = 1'b1;
    logic          sink_gaps   = 1'b1;
    logic          sink_frozen = 1'b0;
    event          sink_hold_ev;

    button_hold_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (sink_frozen) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gaps) begin
            m_axis_tready <= ($urandom_range(99) >= 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always begin
        @(sink_hold_ev);
        sink_frozen <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        sink_frozen <= 1'b0;
    end

    function automatic t_frame_result track_frame(input logic [7:0] raw,
                                                  input logic [QUERY_W-1:0] query);
        t_frame_result r;
        logic [CNT_W-1:0] c;
        int i;
        r = '0;
        for (i = 0; i < BUTTONS; i++) begin
            c = button_counts[i];
            if (!raw[i]) begin
                if (c == RELEASE_MARK) c = '0;
                else if (c >= HOLD_MAX) c = HOLD_MAX;
                else c = c + 1'b1;
            end else begin
                c = (c == '0 || c == RELEASE_MARK) ? '0 : RELEASE_MARK;
            end
            button_counts[i] = c;
            r.pressed_mask[i]  = (c == 8'd1);
            r.released_mask[i] = (c == RELEASE_MARK);
            r.held_mask[i]     = (c != RELEASE_MARK) && ({1'b0, c} == {1'b0, held_time} + 9'd1);
            r.repeat_mask[i]   = (c != '0) && (c != RELEASE_MARK) &&
                                 (repeat_period <= 8'd1 || (c % repeat_period) == 8'd1);
        end
        if (query < BUTTONS && button_counts[query] != RELEASE_MARK)
            r.hold_frames = button_counts[query];
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: %s mismatch, expected %02h, got %02h", name, want, got);
        end
    endfunction

    always @(negedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result %010h", m_axis_tdata);
            end else begin
                want = expected_frames.pop_front();
                compare_field("pressed_mask", want.pressed_mask, got.pressed_mask);
                compare_field("released_mask", want.released_mask, got.released_mask);
                compare_field("held_mask", want.held_mask, got.held_mask);
                compare_field("repeat_mask", want.repeat_mask, got.repeat_mask);
                compare_field("hold_frames", want.hold_frames, got.hold_frames);
            end
        end
    end

    task automatic send_frame(input logic [7:0] raw, input logic [QUERY_W-1:0] query);
        bit taken;
        taken = 1'b0;
        while (src_gaps && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - CNT_W - QUERY_W){1'b0}}, query, raw};
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end
        expected_frames.push_back(track_frame(raw, query));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [7:0] value);
        bit done;
        done = 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(PDATA_W - 8){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        while (!done) begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_HELD_TIME) held_time = value;
        else if (addr == ADDR_REPEAT_PERIOD) repeat_period = value;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] ht, input logic [7:0] rp);
        wait_drained();
        write_reg(ADDR_HELD_TIME, ht);
        write_reg(ADDR_REPEAT_PERIOD, rp);
    endtask

    // Reset settings and then both registers at 0: press, release, a press on
    // the release frame and alternating patterns, with every query index used.
    task automatic test_directed();
        send_frame(8'hFF, 3'd0);
        send_frame(8'h00, 3'd7);
        send_frame(8'h00, 3'd1);
        send_frame(8'hFF, 3'd2);
        send_frame(8'h00, 3'd3);
        send_frame(8'h00, 3'd4);
        send_frame(8'h55, 3'd5);
        send_frame(8'hAA, 3'd6);
        send_frame(8'hAA, 3'd0);
        send_frame(8'hFF, 3'd1);
        send_frame(8'hFF, 3'd2);
        set_config(8'd0, 8'd0);
        send_frame(8'h00, 3'd0);
        send_frame(8'h00, 3'd0);
        send_frame(8'hFE, 3'd0);
        send_frame(8'hFF, 3'd7);
        send_frame(8'hFF, 3'd7);
    endtask

    // All buttons held until the counters saturate, then the held thresholds
    // that can never fire, then release. No idling on either side here.
    task automatic test_long_hold();
        int n;
        src_gaps = 1'b0;
        sink_gaps <= 1'b0;
        set_config(8'd253, 8'd254);
        for (n = 0; n < 258; n++) send_frame(8'h00, n[QUERY_W-1:0]);
        set_config(8'd254, 8'd255);
        for (n = 0; n < 4; n++) send_frame(8'h00, n[QUERY_W-1:0]);
        set_config(8'd255, 8'd0);
        for (n = 0; n < 3; n++) send_frame(8'h00, n[QUERY_W-1:0]);
        send_frame(8'hFF, 3'd5);
        send_frame(8'hFF, 3'd6);
        wait_drained();
        src_gaps = 1'b1;
        sink_gaps <= 1'b1;
    endtask

    // The receiver stops for a long while and the sender keeps offering
    // frames, so the block has to hold back its input.
    task automatic test_backpressure();
        int n;
        set_config(8'd3, 8'd4);
        src_gaps = 1'b0;
        -> sink_hold_ev;
        for (n = 0; n < 12; n++)
            send_frame(8'($urandom_range(255)), 3'($urandom_range(7)));
        wait_drained();
        src_gaps = 1'b1;
    endtask

    task automatic run_random_phase(input logic [7:0] ht, input logic [7:0] rp,
                                    input int frames, input int flip_pct);
        logic [7:0] levels;
        logic [7:0] raw;
        int n;
        int i;
        set_config(ht, rp);
        levels = 8'hFF;
        for (n = 0; n < frames; n++) begin
            if ($urandom_range(99) < 20) begin
                raw = 8'($urandom_range(255));
            end else begin
                for (i = 0; i < BUTTONS; i++)
                    if ($urandom_range(99) < flip_pct) levels[i] = ~levels[i];
                raw = levels;
            end
            send_frame(raw, 3'($urandom_range(7)));
        end
    endtask

    task automatic test_random();
        run_random_phase(8'd1, 8'd0, 110, 4);
        run_random_phase(8'd0, 8'd1, 100, 12);
        run_random_phase(8'($urandom_range(2, 20)), 8'($urandom_range(2, 12)), 130, 3);
        run_random_phase(8'd253, 8'd254, 90, 40);
        run_random_phase(8'($urandom_range(1, 253)), 8'($urandom_range(0, 254)), 140, 5);
        run_random_phase(8'($urandom_range(2, 10)), 8'($urandom_range(2, 6)), 134, 8);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_hold();
        test_backpressure();
        test_random();
        wait_drained();
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
